@@ design/console_line_editor_top_macros.svh @@
// ---------------------------------------------------------------------------
// Console line editor assertion macros
// Shared concurrent assertion forms for the line editor RTL.
// ---------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_TOP_MACROS_SVH
`define CONSOLE_LINE_EDITOR_TOP_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define CLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define CLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/cle_pkg.sv @@
// ---------------------------------------------------------------------------
// Console line editor package
// Key codes, drain sequencer states and the line request between modules.
// ---------------------------------------------------------------------------
package cle_pkg;

  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_NL   = 8'h0A;
  localparam logic [7:0] KEY_KILL = 8'h15;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_READ,
    DR_TAIL,
    DR_EOF
  } drain_state_t;

  // Hand-off of a finished line from the editor to the drain sequencer.
  typedef struct packed {
    logic go;
    logic empty;
  } line_req_t;

endpackage

@@ design/cle_line_ram.sv @@
// ---------------------------------------------------------------------------
// Console line editor line store
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
module cle_line_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a waiting byte is not lost.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/cle_editor.sv @@
// ---------------------------------------------------------------------------
// Console line editor input decoder
// Applies raw or cooked editing to each byte and keeps the fill count.
// ---------------------------------------------------------------------------
module cle_editor #(
  parameter int LINE_LEN = 64,
  parameter int AW       = 6,
  parameter int FW       = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_more_pending,
  input  logic               drain_idle,
  output cle_pkg::line_req_t req,
  output logic [FW-1:0]      req_len,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data
);

  localparam logic [FW-1:0] FULL = FW'(LINE_LEN);
  localparam logic [FW-1:0] ONE  = FW'(1);

  logic          raw_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [FW-1:0] fill_after;
  logic          accept;
  logic          do_store;
  logic          do_send;
  logic          do_clear;
  logic          do_erase;
  logic          room;
  logic          go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= 1'b0;
    end else if (cfg_wr_en) begin
      raw_r <= cfg_wr_data;
    end
  end

  assign in_stall = !drain_idle;
  assign accept   = in_valid && !in_stall;
  assign room     = (fill_r < FULL);

  always_comb begin
    do_store = 1'b0;
    do_send  = 1'b0;
    do_clear = 1'b0;
    do_erase = 1'b0;
    if (in_byte == cle_pkg::KEY_NUL) begin
      do_send = (fill_r != '0) && !in_more_pending;
    end else if (raw_r) begin
      do_store = 1'b1;
      do_send  = !in_more_pending;
    end else begin
      case (in_byte)
        cle_pkg::KEY_BS: begin
          do_erase = (fill_r != '0);
        end
        cle_pkg::KEY_KILL: begin
          do_clear = 1'b1;
        end
        cle_pkg::KEY_NL: begin
          do_store = 1'b1;
          do_send  = 1'b1;
        end
        cle_pkg::KEY_EOF: begin
          do_send = 1'b1;
        end
        default: begin
          do_store = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (do_clear) begin
      fill_after = '0;
    end else if (do_erase) begin
      fill_after = fill_r - ONE;
    end else if (do_store && room) begin
      fill_after = fill_r + ONE;
    end else begin
      fill_after = fill_r;
    end
  end

  // A full store sends the line whatever the mode or pending flag.
  assign go = accept && (do_send || (fill_after == FULL));

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = go ? '0 : fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign req.go    = go;
  assign req.empty = (fill_after == '0);
  assign req_len   = fill_after;

  assign wr_en   = accept && do_store && room;
  assign wr_addr = fill_r[AW-1:0];
  assign wr_data = in_byte;

endmodule

@@ design/cle_drain.sv @@
// ---------------------------------------------------------------------------
// Console line editor drain sequencer
// Reads a finished line from the store and presents it on the result channel.
// ---------------------------------------------------------------------------
`include "console_line_editor_top_macros.svh"

module cle_drain #(
  parameter int AW = 6,
  parameter int FW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cle_pkg::line_req_t req,
  input  logic [FW-1:0]      req_len,
  output logic               drain_idle,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [7:0]         rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_empty_line,
  output logic               out_last
);

  localparam logic [FW-1:0] ONE = FW'(1);

  cle_pkg::drain_state_t state_r;
  cle_pkg::drain_state_t state_nxt;

  logic [FW-1:0] len_r;
  logic [FW-1:0] rd_idx_r;
  logic          rd_pend_r;
  logic          rd_pend_nxt;
  logic          rd_last_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_empty_r;
  logic          out_last_r;
  logic          slot_free;
  logic          is_last;
  logic          issue;
  logic          load;
  logic          eof_load;

  assign slot_free = !out_valid_r || !out_stall;
  assign is_last   = (rd_idx_r == (len_r - ONE));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cle_pkg::DR_IDLE: begin
        if (req.go) begin
          state_nxt = req.empty ? cle_pkg::DR_EOF : cle_pkg::DR_READ;
        end
      end
      cle_pkg::DR_READ: begin
        if (issue && is_last) begin
          state_nxt = cle_pkg::DR_TAIL;
        end
      end
      cle_pkg::DR_TAIL: begin
        if (load) begin
          state_nxt = cle_pkg::DR_IDLE;
        end
      end
      cle_pkg::DR_EOF: begin
        if (slot_free) begin
          state_nxt = cle_pkg::DR_IDLE;
        end
      end
      default: begin
        state_nxt = cle_pkg::DR_IDLE;
      end
    endcase
  end

  always_comb begin
    load     = rd_pend_r && slot_free;
    issue    = 1'b0;
    eof_load = 1'b0;
    case (state_r)
      cle_pkg::DR_READ: begin
        issue = !rd_pend_r || load;
      end
      cle_pkg::DR_EOF: begin
        eof_load = slot_free;
      end
      default: begin
        issue    = 1'b0;
        eof_load = 1'b0;
      end
    endcase
  end

  assign drain_idle = (state_r == cle_pkg::DR_IDLE);
  assign rd_en      = issue;
  assign rd_addr    = rd_idx_r[AW-1:0];

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (issue) begin
      rd_pend_nxt = 1'b1;
    end else if (load) begin
      rd_pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load || eof_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cle_pkg::DR_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      len_r    <= req_len;
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r <= rd_idx_r + ONE;
    end
    if (issue) begin
      rd_last_r <= is_last;
    end
    if (load) begin
      out_byte_r  <= rd_data;
      out_empty_r <= 1'b0;
      out_last_r  <= rd_last_r;
    end else if (eof_load) begin
      out_byte_r  <= cle_pkg::KEY_NUL;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_empty_line = out_empty_r;
  assign out_last       = out_last_r;

  `CLE_ASSERT(a_go_only_idle, req.go |-> state_r == cle_pkg::DR_IDLE, "line sent while draining")
  `CLE_ASSERT(a_no_read_idle, state_r == cle_pkg::DR_IDLE |-> !rd_pend_r, "read left in flight")
  `CLE_ASSERT(a_idx_in_line, state_r == cle_pkg::DR_READ |-> rd_idx_r < len_r, "read past line end")
  `CLE_ASSERT(a_tail_pending, state_r == cle_pkg::DR_TAIL |-> rd_pend_r, "tail without read")
  `CLE_ASSERT(a_empty_is_last, out_valid_r && out_empty_r |-> out_last_r && out_byte_r == 8'h00, "bad empty line result")

endmodule

@@ design/console_line_editor_top.sv @@
// ---------------------------------------------------------------------------
// Console line editor
// Canonical keyboard line discipline with a memory-based line store.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                                                     Flow
//   -------  --------------------------------------------------------  ----
//   input    in_valid, in_stall, in_byte, in_more_pending               in
//   result   out_valid, out_stall, out_byte, out_empty_line, out_last   out
//   config   cfg_wr_en, cfg_wr_data (raw_mode)                          in
//
// While a line is edited and the drain is idle, one byte transfer is taken every
// cycle and a stored byte is written into the line store at the fill index at once.
// A finished line of n bytes drains through the store's single read port, one
// read per byte, and an empty line drains as a single empty-line result.
// The input side is stalled for as long as the drain is busy.
// Synchronous reset clears the fill count, raw mode and the drain sequencer.
//
module console_line_editor_top #(
  parameter int LINE_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_more_pending,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_empty_line,
  output logic       out_last
);

  // Address width of the store, and fill width that can hold LINE_LEN itself.
  localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int FW = $clog2(LINE_LEN + 1);

  cle_pkg::line_req_t req;
  logic [FW-1:0]      req_len;
  logic               drain_idle;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;

  // The editor decodes each byte, writes stored bytes and hands a finished
  // line over as a length. It takes transfers only while the drain is idle,
  // so store writes and store reads never overlap.
  cle_editor #(
    .LINE_LEN (LINE_LEN),
    .AW       (AW),
    .FW       (FW)
  ) u_editor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_more_pending (in_more_pending),
    .drain_idle      (drain_idle),
    .req             (req),
    .req_len         (req_len),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  cle_line_ram #(
    .DEPTH (LINE_LEN),
    .AW    (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The drain issues one read per cycle as long as no earlier read is still
  // waiting for the output register; held read data covers a stalled result.
  cle_drain #(
    .AW (AW),
    .FW (FW)
  ) u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .req_len        (req_len),
    .drain_idle     (drain_idle),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_empty_line (out_empty_line),
    .out_last       (out_last)
  );

endmodule
